[hw/rtl/clsw_pkg.sv]
package clsw_pkg;

  localparam int unsigned PortW = 5;

  typedef logic [PortW-1:0] ext_t;

  typedef enum logic [2:0] {
    ST_ON_HOOK   = 3'd0,
    ST_RINGING   = 3'd1,
    ST_DIAL_TONE = 3'd2,
    ST_RING_BACK = 3'd3,
    ST_BUSY      = 3'd4,
    ST_CONNECTED = 3'd5,
    ST_ERROR     = 3'd6
  } line_state_e;

  typedef enum logic [1:0] {
    OP_PICKUP = 2'd0,
    OP_HANGUP = 2'd1,
    OP_DIAL   = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    FSM_CLEAR  = 3'd0,
    FSM_IDLE   = 3'd1,
    FSM_LINE   = 3'd2,
    FSM_TARGET = 3'd3,
    FSM_SECOND = 3'd4
  } fsm_e;

  typedef struct packed {
    ext_t        line;
    line_state_e state;
    ext_t        number;
    logic        has_number;
    logic        status;
    logic        last;
  } notice_t;

endpackage

[hw/rtl/call_line_state_switch.sv]
// Call-state switch for a table of telephone lines. Each line's call state and
// peer live in one synchronous memory entry. After reset the block clears the
// table, one entry per cycle, with busy_o high. An event is a transfer on
// start_i while busy_o is low; events on an unused opcode or a line beyond the
// table are taken and dropped. The line's entry is read, then the block
// decides: an event with one notice holds busy_o high only through FSM_LINE,
// an event that touches a second line adds FSM_SECOND to write that line's
// entry through the single write port, and a dial to a valid target adds
// FSM_TARGET to read the target's entry. Notices come out registered, one per
// strobe_o pulse, with last_o on the final one; the receiver cannot stall
// them, and the next event may be taken in the cycle a final notice is shown.
module call_line_state_switch import clsw_pkg::*; #(
  parameter int unsigned NUM_LINES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          opcode_i,
  input  logic [PortW-1:0]    line_i,
  input  logic [PortW-1:0]    target_line_i,
  input  logic                target_known_i,
  output logic                strobe_o,
  output logic [PortW-1:0]    notified_line_o,
  output logic [2:0]          line_state_o,
  output logic [PortW-1:0]    number_o,
  output logic                has_number_o,
  output logic                status_o,
  output logic                last_o
);

  localparam int unsigned LW = $clog2(NUM_LINES);
  localparam int unsigned EW = 3 + 1 + LW;

  typedef logic [LW-1:0] idx_t;
  typedef logic [EW-1:0] entry_t;

  fsm_e        state_q, state_d;
  idx_t        clr_q;
  opcode_e     op_q;
  idx_t        line_q, tgt_q;
  logic        tgt_ok_q;
  notice_t     out_q, out_d, n2_q, n2_d;
  logic        strobe_q, strobe_d;
  idx_t        sec_addr_q, sec_addr_d;
  entry_t      sec_data_q, sec_data_d;

  logic        mem_we, mem_re;
  idx_t        mem_waddr, mem_raddr;
  entry_t      mem_wdata, mem_rdata;

  logic        accept, item_ok, go_target, go_second;
  line_state_e rd_st;
  logic        rd_pp;
  idx_t        rd_pl;
  ext_t        line_x, peer_x, tgt_x;

  function automatic notice_t mk_notice(ext_t who, line_state_e st, logic hn, ext_t num,
                                        logic stat, logic lst);
    notice_t n;
    n.line       = who;
    n.state      = st;
    n.number     = hn ? num : '0;
    n.has_number = hn;
    n.status     = stat;
    n.last       = lst;
    return n;
  endfunction

  function automatic entry_t mk_entry(line_state_e st, logic pp, idx_t pl);
    return {st, pp, pl};
  endfunction

  clsw_ram #(
    .Depth(NUM_LINES),
    .Width(EW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign busy_o  = (state_q != FSM_IDLE);
  assign accept  = start_i && !busy_o;
  assign item_ok = (32'(line_i) < NUM_LINES) &&
                   ((opcode_e'(opcode_i) == OP_PICKUP) ||
                    (opcode_e'(opcode_i) == OP_HANGUP) ||
                    (opcode_e'(opcode_i) == OP_DIAL));

  assign rd_st  = line_state_e'(mem_rdata[EW-1 -: 3]);
  assign rd_pp  = mem_rdata[LW];
  assign rd_pl  = mem_rdata[LW-1:0];
  assign line_x = PortW'(line_q);
  assign peer_x = PortW'(rd_pl);
  assign tgt_x  = PortW'(tgt_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_CLEAR: begin
        if (clr_q == LW'(NUM_LINES - 1)) begin
          state_d = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (accept && item_ok) begin
          state_d = FSM_LINE;
        end
      end
      FSM_LINE: begin
        if (go_target) begin
          state_d = FSM_TARGET;
        end else if (go_second) begin
          state_d = FSM_SECOND;
        end else begin
          state_d = FSM_IDLE;
        end
      end
      FSM_TARGET: begin
        state_d = go_second ? FSM_SECOND : FSM_IDLE;
      end
      FSM_SECOND: begin
        state_d = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = line_q;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = line_q;
    strobe_d   = 1'b0;
    out_d      = out_q;
    n2_d       = n2_q;
    sec_addr_d = sec_addr_q;
    sec_data_d = sec_data_q;
    go_target  = 1'b0;
    go_second  = 1'b0;
    unique case (state_q)
      FSM_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = mk_entry(ST_ON_HOOK, 1'b0, '0);
      end
      FSM_IDLE: begin
        mem_re    = accept && item_ok;
        mem_raddr = LW'(line_i);
      end
      FSM_LINE: begin
        unique case (op_q)
          OP_PICKUP: begin
            if (rd_st == ST_ON_HOOK) begin
              mem_we    = 1'b1;
              mem_wdata = mk_entry(ST_DIAL_TONE, rd_pp, rd_pl);
              strobe_d  = 1'b1;
              out_d     = mk_notice(line_x, ST_DIAL_TONE, 1'b0, '0, 1'b0, 1'b1);
            end else if (rd_st == ST_RINGING) begin
              if (rd_pp) begin
                mem_we     = 1'b1;
                mem_wdata  = mk_entry(ST_CONNECTED, rd_pp, rd_pl);
                strobe_d   = 1'b1;
                out_d      = mk_notice(line_x, ST_CONNECTED, 1'b1, peer_x, 1'b0, 1'b0);
                go_second  = 1'b1;
                sec_addr_d = rd_pl;
                sec_data_d = mk_entry(ST_CONNECTED, 1'b1, line_q);
                n2_d       = mk_notice(peer_x, ST_CONNECTED, 1'b1, line_x, 1'b0, 1'b1);
              end
            end else begin
              strobe_d = 1'b1;
              out_d    = mk_notice(line_x, rd_st, (rd_st == ST_CONNECTED) && rd_pp,
                                   peer_x, 1'b0, 1'b1);
            end
          end
          OP_HANGUP: begin
            if ((rd_st == ST_CONNECTED) || (rd_st == ST_RINGING) ||
                (rd_st == ST_RING_BACK)) begin
              if (rd_pp) begin
                mem_we     = 1'b1;
                mem_wdata  = mk_entry(ST_ON_HOOK, 1'b0, '0);
                strobe_d   = 1'b1;
                out_d      = mk_notice(line_x, ST_ON_HOOK, 1'b1, line_x, 1'b0, 1'b0);
                go_second  = 1'b1;
                sec_addr_d = rd_pl;
                if (rd_st == ST_RING_BACK) begin
                  sec_data_d = mk_entry(ST_ON_HOOK, 1'b0, '0);
                  n2_d       = mk_notice(peer_x, ST_ON_HOOK, 1'b1, peer_x, 1'b0, 1'b1);
                end else begin
                  sec_data_d = mk_entry(ST_DIAL_TONE, 1'b0, '0);
                  n2_d       = mk_notice(peer_x, ST_DIAL_TONE, 1'b0, '0, 1'b0, 1'b1);
                end
              end
            end else begin
              mem_we    = 1'b1;
              mem_wdata = mk_entry(ST_ON_HOOK, 1'b0, '0);
              strobe_d  = 1'b1;
              out_d     = mk_notice(line_x, ST_ON_HOOK, 1'b1, line_x, 1'b0, 1'b1);
            end
          end
          OP_DIAL: begin
            if (rd_st != ST_DIAL_TONE) begin
              strobe_d = 1'b1;
              out_d    = mk_notice(line_x, rd_st, rd_st == ST_ON_HOOK, line_x, 1'b0, 1'b1);
            end else if (!tgt_ok_q) begin
              mem_we    = 1'b1;
              mem_wdata = mk_entry(ST_ERROR, rd_pp, rd_pl);
              strobe_d  = 1'b1;
              out_d     = mk_notice(line_x, ST_ERROR, 1'b0, '0, 1'b1, 1'b1);
            end else if (tgt_q == line_q) begin
              mem_we    = 1'b1;
              mem_wdata = mk_entry(ST_BUSY, rd_pp, rd_pl);
              strobe_d  = 1'b1;
              out_d     = mk_notice(line_x, ST_BUSY, 1'b0, '0, 1'b0, 1'b1);
            end else begin
              go_target = 1'b1;
              mem_re    = 1'b1;
              mem_raddr = tgt_q;
            end
          end
          default: begin
          end
        endcase
      end
      FSM_TARGET: begin
        mem_we   = 1'b1;
        strobe_d = 1'b1;
        if ((rd_st != ST_ON_HOOK) || rd_pp) begin
          mem_wdata = mk_entry(ST_BUSY, 1'b0, '0);
          out_d     = mk_notice(line_x, ST_BUSY, 1'b0, '0, 1'b0, 1'b1);
        end else begin
          mem_wdata  = mk_entry(ST_RING_BACK, 1'b1, tgt_q);
          out_d      = mk_notice(line_x, ST_RING_BACK, 1'b0, '0, 1'b0, 1'b0);
          go_second  = 1'b1;
          sec_addr_d = tgt_q;
          sec_data_d = mk_entry(ST_RINGING, 1'b1, line_q);
          n2_d       = mk_notice(tgt_x, ST_RINGING, 1'b0, '0, 1'b0, 1'b1);
        end
      end
      FSM_SECOND: begin
        mem_we    = 1'b1;
        mem_waddr = sec_addr_q;
        mem_wdata = sec_data_q;
        strobe_d  = 1'b1;
        out_d     = n2_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_CLEAR;
      clr_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      if (state_q == FSM_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && item_ok) begin
      op_q     <= opcode_e'(opcode_i);
      line_q   <= LW'(line_i);
      tgt_q    <= LW'(target_line_i);
      tgt_ok_q <= target_known_i && (32'(target_line_i) < NUM_LINES);
    end
    out_q      <= out_d;
    n2_q       <= n2_d;
    sec_addr_q <= sec_addr_d;
    sec_data_q <= sec_data_d;
  end

  assign strobe_o        = strobe_q;
  assign notified_line_o = out_q.line;
  assign line_state_o    = out_q.state;
  assign number_o        = out_q.number;
  assign has_number_o    = out_q.has_number;
  assign status_o        = out_q.status;
  assign last_o          = out_q.last;

endmodule

[hw/rtl/clsw_ram.sv]
module clsw_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 9,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
